### design/gnss_observation_qualifier_defines.svh
// assertion macros shared by the qualifier files
// each macro expects clk and arst_n in scope
`ifndef GNSS_OBSERVATION_QUALIFIER_DEFINES_SVH
`define GNSS_OBSERVATION_QUALIFIER_DEFINES_SVH

// same-cycle implication
`define GNSSOQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gnssoq: same-cycle check failed");

// next-cycle implication
`define GNSSOQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gnssoq: next-cycle check failed");

`endif

### design/gnssoq_pkg.sv
`timescale 1ns / 1ps
package gnssoq_pkg;

	// default table and epoch sizes
	localparam int SAT_SLOTS_DEF    = 32;
	localparam int MAX_CHANNELS_DEF = 64;

	// stream widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 29;
	localparam logic [CFG_IDX_W-1:0] CFG_CN0_MIN    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE_MS = 1'b1;
	localparam logic [7:0]  CN0_MIN_RST    = 8'd30;
	localparam logic [28:0] MAX_AGE_MS_RST = 29'd7200000;

	// item kinds and constellation codes
	localparam logic OP_OBS = 1'b0;
	localparam logic OP_EPH = 1'b1;
	localparam logic [2:0] CONS_GPS = 3'd1;

	// time arithmetic
	localparam logic [29:0] MS_PER_S = 30'd1000;
	localparam logic signed [31:0] HALF_WEEK_MS = 32'sd302400000;
	localparam logic signed [31:0] FULL_WEEK_MS = 32'sd604800000;

	// slot entry: health word over reference time
	localparam int SLOT_DATA_W = 26;

	// epoch counters hold 0 .. 64
	localparam int CNT_W = 7;

	typedef struct packed {
		logic load;
		logic rd;
		logic mul;
		logic sub;
		logic cor;
		logic fin;
	} gnssoq_cmd_t;

	typedef struct packed {
		logic is_write;
	} gnssoq_stat_t;

endpackage

### design/gnssoq_ram.sv
`timescale 1ns / 1ps
module gnssoq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/gnssoq_ctrl.sv
`timescale 1ns / 1ps
module gnssoq_ctrl
	import gnssoq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  gnssoq_stat_t stat,
	output gnssoq_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUB  = 3'd3;
	localparam logic [2:0] ST_COR  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// sequencing of one item through the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = stat.is_write ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUB;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_COR;
			end
			ST_COR: begin
				cmd.cor = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

### design/gnssoq_dp.sv
`timescale 1ns / 1ps
module gnssoq_dp
	import gnssoq_pkg::*;
#(
	parameter int SAT_SLOTS    = SAT_SLOTS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  s_tlast,
	input  gnssoq_cmd_t           cmd,
	output gnssoq_stat_t          stat,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	localparam int SLOT_W = (SAT_SLOTS > 1) ? $clog2(SAT_SLOTS) : 1;

	// configuration registers
	logic [7:0]  cn0_min_q;
	logic [28:0] max_age_ms_q;

	// captured item
	logic        opcode_q;
	logic [5:0]  prn_q;
	logic [2:0]  cons_q;
	logic [2:0]  lli_q;
	logic        locked_q;
	logic [7:0]  cn0_q;
	logic [29:0] t_ms_q;
	logic [5:0]  health_q;
	logic [19:0] ref_s_q;
	logic        last_q;

	// slot table
	logic [SAT_SLOTS-1:0]   slot_valid_q;
	logic                   valid_s1;
	logic [SLOT_DATA_W-1:0] slot_rdata;
	logic [SLOT_W-1:0]      slot_idx;
	logic [5:0]             prn_m1;
	logic                   prn_ok;
	logic                   slot_we;

	// age chain and checks
	logic               slot_ok_s2;
	logic               pre_ok_s2;
	logic [29:0]        prod_s2;
	logic signed [31:0] tk_s3;
	logic signed [31:0] tkc_s4;
	logic signed [31:0] max_age_s;
	logic               age_ok;

	// epoch counters and result
	logic [CNT_W-1:0] chan_cnt_q;
	logic [CNT_W-1:0] acc_cnt_q;
	logic             chan_room;
	logic             obs_ok;
	logic [CNT_W-1:0] acc_next;
	logic [5:0]       pos;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	assign stat.is_write = (opcode_q == OP_EPH);

	// slot index, parked at zero for a prn outside the table
	assign prn_ok   = (prn_q != 6'd0) && (prn_q <= 6'(SAT_SLOTS));
	assign prn_m1   = prn_q - 6'd1;
	assign slot_idx = prn_ok ? prn_m1[SLOT_W-1:0] : '0;
	assign slot_we  = cmd.fin && stat.is_write && prn_ok;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cn0_min_q    <= CN0_MIN_RST;
			max_age_ms_q <= MAX_AGE_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CN0_MIN:    cn0_min_q    <= cfg_wdata[7:0];
				CFG_MAX_AGE_MS: max_age_ms_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input capture on an accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			opcode_q <= s_tuser;
			prn_q    <= s_tdata[5:0];
			cons_q   <= s_tdata[8:6];
			lli_q    <= s_tdata[11:9];
			locked_q <= s_tdata[12];
			cn0_q    <= s_tdata[20:13];
			t_ms_q   <= s_tdata[50:21];
			health_q <= s_tdata[56:51];
			ref_s_q  <= s_tdata[76:57];
			last_q   <= s_tlast;
		end
	end

	gnssoq_ram #(
		.WIDTH (SLOT_DATA_W),
		.DEPTH (SAT_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_idx),
		.wdata ({health_q, ref_s_q}),
		.re    (cmd.rd),
		.raddr (slot_idx),
		.rdata (slot_rdata)
	);

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (slot_we) begin
			slot_valid_q[slot_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			valid_s1 <= slot_valid_q[slot_idx];
		end
	end

	// reference time to ms, slot health and channel checks
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s2    <= {10'd0, slot_rdata[19:0]} * MS_PER_S;
			slot_ok_s2 <= valid_s1 && (slot_rdata[25:20] == 6'd0);
			pre_ok_s2  <= (cons_q == CONS_GPS) && prn_ok && (lli_q == 3'd0) &&
				locked_q && (cn0_q >= cn0_min_q);
		end
	end

	// raw age
	always_ff @(posedge clk) begin
		if (cmd.sub) begin
			tk_s3 <= $signed({2'b00, t_ms_q}) - $signed({2'b00, prod_s2});
		end
	end

	// single week-rollover correction
	always_ff @(posedge clk) begin
		if (cmd.cor) begin
			if (tk_s3 > HALF_WEEK_MS) begin
				tkc_s4 <= tk_s3 - FULL_WEEK_MS;
			end else if (tk_s3 < -HALF_WEEK_MS) begin
				tkc_s4 <= tk_s3 + FULL_WEEK_MS;
			end else begin
				tkc_s4 <= tk_s3;
			end
		end
	end

	// absolute age against the limit, as a window around zero
	assign max_age_s = $signed({3'b000, max_age_ms_q});
	assign age_ok    = (tkc_s4 <= max_age_s) && (tkc_s4 >= -max_age_s);

	assign chan_room = (chan_cnt_q < CNT_W'(MAX_CHANNELS));
	assign obs_ok    = chan_room && pre_ok_s2 && slot_ok_s2 && age_ok;
	assign acc_next  = acc_cnt_q + {{(CNT_W-1){1'b0}}, obs_ok};
	assign pos       = chan_room ? chan_cnt_q[5:0] : 6'(MAX_CHANNELS - 1);

	// epoch counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= '0;
			acc_cnt_q  <= '0;
		end else if (cmd.fin && !stat.is_write) begin
			if (last_q) begin
				chan_cnt_q <= '0;
				acc_cnt_q  <= '0;
			end else begin
				chan_cnt_q <= chan_cnt_q + {{(CNT_W-1){1'b0}}, chan_room};
				acc_cnt_q  <= acc_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (stat.is_write) begin
				out_data_q <= {15'd0, prn_ok};
				out_last_q <= 1'b0;
			end else begin
				out_data_q <= {2'b00, acc_next, pos, obs_ok};
				out_last_q <= last_q;
			end
		end
	end

	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

endmodule

### design/gnss_observation_qualifier.sv
`timescale 1ns / 1ps
// Qualifies GNSS observation channels against a per-satellite ephemeris table
// and loads that table from ephemeris-write transactions (tuser high). One
// result follows every transaction. The controller walks each observation
// channel through the slot table's registered read, the reference-time
// multiply, the age subtract and the week-rollover correction before the
// final compare loads the output register; an ephemeris write goes from the
// read straight to the final step. The next transaction is accepted only
// after the block has returned to idle. A result waiting on m_tready holds
// the block in its last step. The valid bits of the slot table clear at
// reset; no clearing pass is needed.
`include "gnss_observation_qualifier_defines.svh"
module gnss_observation_qualifier
	import gnssoq_pkg::*;
#(
	parameter int SAT_SLOTS    = SAT_SLOTS_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sat_prn, constellation, loss_of_lock, carrier_locked, cn0_dbhz,
	// epoch_time_ms, health_word, ref_time_s, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                  s_tuser,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// accepted, channel_position, accepted_count, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	gnssoq_cmd_t  cmd;
	gnssoq_stat_t stat;

	gnssoq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gnssoq_dp #(
		.SAT_SLOTS    (SAT_SLOTS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// one transaction at a time: input closes right after acceptance
	`GNSSOQ_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// a result is only loaded when the output register is free
	`GNSSOQ_ASSERT_IMP(a_fin_out_free, cmd.fin, !m_tvalid || m_tready)
	// an accepted closing channel counts at least itself
	`GNSSOQ_ASSERT_IMP(a_acc_count, m_tvalid && m_tdata[0] && m_tlast, m_tdata[13:7] != 7'd0)

endmodule
